// ===== src/lrucd_pkg.sv =====
package lrucd_pkg;

  localparam int unsigned ObjBits = 23;
  localparam int unsigned GenBits = 16;
  localparam int unsigned KeyBits = ObjBits + GenBits;
  localparam int unsigned OccBits = 5;
  localparam int unsigned CapBits = 5;

  localparam logic [CapBits-1:0] CapReset = 5'd16;

  typedef enum logic {
    OpAccess = 1'b0,
    OpClear  = 1'b1
  } op_e;

  typedef struct packed {
    logic               hit;
    logic               ev_valid;
    logic [ObjBits-1:0] ev_obj;
    logic [GenBits-1:0] ev_gen;
    logic [OccBits-1:0] occ;
    logic               last;
  } result_t;

endpackage

// ===== src/lru_reference_cache_directory_unit.sv =====
// a taken transaction sits in the input register; its results are registered in the output one
// throughput, output ready: one transaction per cycle; hits, clears, misses with <=1 eviction
// a miss evicting k keys holds the input register for k results, one oldest-entry eviction each
// reset (async, active low): directory emptied, occupancy zero, capacity 16
// key storage is not cleared and needs no clearing pass
module lru_reference_cache_directory_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // object_number[22:0], generation[38:23], zero pad
  input  logic [0:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // evicted_object, evicted_generation, occupancy, pad
  output logic [1:0]  m_axis_tuser,   // hit, evicted_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);
  import lrucd_pkg::*;

  logic               in_valid_q;
  op_e                in_op_q;
  logic [KeyBits-1:0] in_key_q;
  logic               out_valid_q;
  result_t            out_res_q;
  logic [CapBits-1:0] cap_q;

  result_t res;
  logic    step;
  logic    consume;
  logic    in_take;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  // item leaves the input register once its final result is produced
  assign consume       = step && res.last;
  assign s_axis_tready = !in_valid_q || consume;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  lrucd_dir #(
    .Slots(SLOTS)
  ) u_dir (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .op_i  (in_op_q),
    .key_i (in_key_q),
    .cap_i (cap_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= CapReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= op_e'(s_axis_tuser[0]);
      in_key_q <= s_axis_tdata[KeyBits-1:0];
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_res_q.occ, out_res_q.ev_gen, out_res_q.ev_obj};
  assign m_axis_tuser  = {out_res_q.ev_valid, out_res_q.hit};
  assign m_axis_tlast  = out_res_q.last;

`ifndef ASSERT_OFF
  a_hit_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tuser[1])
    else $error("hit result must be a single non-eviction transaction");

  a_plain_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tlast)
    else $error("result without eviction must be final");

  a_stall_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && !consume)
    else $error("input stalled without a pending item");

  a_evict_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !res.last |=> in_valid_q)
    else $error("item dropped before its final eviction");
`endif

endmodule

// ===== src/lrucd_dir.sv =====
module lrucd_dir #(
  parameter int unsigned Slots = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  lrucd_pkg::op_e                op_i,
  input  logic [lrucd_pkg::KeyBits-1:0] key_i,
  input  logic [lrucd_pkg::CapBits-1:0] cap_i,
  output lrucd_pkg::result_t            res_o
);
  import lrucd_pkg::*;

  localparam int unsigned RW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned EW = (CW > CapBits) ? CW : CapBits;
  localparam int unsigned OW = CW + OccBits;

  logic [KeyBits-1:0] key_q [Slots];
  logic [Slots-1:0]   valid_q, valid_d;
  logic [RW-1:0]      rank_q [Slots];
  logic [RW-1:0]      rank_d [Slots];
  logic [CW-1:0]      held_q, held_d;

  logic [Slots-1:0]   match;
  logic [Slots-1:0]   oldest;
  logic [Slots-1:0]   evict_sel;
  logic [Slots-1:0]   valid_after;
  logic [Slots-1:0]   free_vec;
  logic [Slots-1:0]   ins_sel;
  logic               hit;
  logic [RW-1:0]      hit_rank;
  logic [KeyBits-1:0] ev_key;
  logic [EW-1:0]      cap_ext;
  logic [EW-1:0]      eff;
  logic [EW-1:0]      held_ext;
  logic               need_evict;
  logic               last_evict;
  logic               insert;
  logic [CW-1:0]      held_after;
  logic [OW-1:0]      occ_wide;

  // parallel tag compare, oldest-entry detection, eviction and insert-slot selection
  always_comb begin
    hit_rank = '0;
    ev_key   = '0;
    for (int i = 0; i < Slots; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == key_i);
      oldest[i] = valid_q[i] && (CW'(rank_q[i]) == held_q - CW'(1));
    end
    hit = |match;
    cap_ext = EW'(cap_i);
    eff = (cap_ext > EW'(Slots)) ? EW'(Slots) : cap_ext;
    if (eff == '0) begin
      eff = EW'(1);
    end
    held_ext   = EW'(held_q);
    need_evict = held_ext >= eff;
    last_evict = held_ext == eff;
    insert     = !need_evict || last_evict;
    evict_sel  = need_evict ? oldest : '0;
    for (int i = 0; i < Slots; i++) begin
      if (match[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
      if (evict_sel[i]) begin
        ev_key = ev_key | key_q[i];
      end
    end
    valid_after = valid_q & ~evict_sel;
    free_vec    = ~valid_after;
    // lowest free entry, one-hot
    ins_sel     = free_vec & (~free_vec + Slots'(1));
    held_after  = held_q - CW'(need_evict);
  end

  always_comb begin
    valid_d = valid_q;
    held_d  = held_q;
    for (int i = 0; i < Slots; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (step_i) begin
      if (op_i == OpClear) begin
        valid_d = '0;
        held_d  = '0;
        for (int i = 0; i < Slots; i++) begin
          rank_d[i] = '0;
        end
      end else if (hit) begin
        for (int i = 0; i < Slots; i++) begin
          if (match[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
      end else begin
        valid_d = valid_after;
        held_d  = held_after;
        if (insert) begin
          valid_d = valid_after | ins_sel;
          held_d  = held_after + CW'(1);
          for (int i = 0; i < Slots; i++) begin
            if (ins_sel[i]) begin
              rank_d[i] = '0;
            end else if (valid_after[i]) begin
              rank_d[i] = rank_q[i] + RW'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    res_o    = '0;
    occ_wide = '0;
    if (op_i == OpClear) begin
      res_o.last = 1'b1;
    end else if (hit) begin
      occ_wide   = OW'(held_q);
      res_o.hit  = 1'b1;
      res_o.last = 1'b1;
    end else if (need_evict) begin
      // count includes the key that is about to go in
      occ_wide       = OW'(held_q);
      res_o.ev_valid = 1'b1;
      res_o.ev_obj   = ev_key[ObjBits-1:0];
      res_o.ev_gen   = ev_key[KeyBits-1:ObjBits];
      res_o.last     = last_evict;
    end else begin
      occ_wide   = OW'(held_q) + OW'(1);
      res_o.last = 1'b1;
    end
    res_o.occ = occ_wide[OccBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      held_q  <= '0;
      for (int i = 0; i < Slots; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      held_q  <= held_d;
      for (int i = 0; i < Slots; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && (op_i == OpAccess) && !hit && insert) begin
      for (int i = 0; i < Slots; i++) begin
        if (ins_sel[i]) begin
          key_q[i] <= key_i;
        end
      end
    end
  end

endmodule

// ===== tb/sv/lru_reference_cache_directory_unit_tb.sv =====
`timescale 1ns / 1ps

module lru_reference_cache_directory_unit_tb;
  import lrucd_pkg::*;

  localparam int unsigned DirSlots = 16;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned NumPhases = 9;
  localparam longint unsigned CycleLimit = 400000;

  // tracks directory contents and holds the results each request must produce
  class lru_directory_scoreboard;
    logic [ObjBits-1:0] slot_obj [DirSlots];
    logic [GenBits-1:0] slot_gen [DirSlots];
    bit                 slot_used [DirSlots];
    int unsigned        slot_rank [DirSlots];
    int unsigned        held;
    logic [CapBits-1:0] capacity;
    result_t            outcome_q [$];
    int unsigned        mismatches;

    function new();
      empty_directory();
      capacity   = CapReset;
      mismatches = 0;
    endfunction

    function void empty_directory();
      for (int i = 0; i < DirSlots; i++) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
      end
      held = 0;
    endfunction

    function void apply_request(op_e op, logic [ObjBits-1:0] obj, logic [GenBits-1:0] gen);
      result_t     r;
      int          hit_slot;
      int          free_slot;
      int          victim;
      int unsigned eff;
      int unsigned evict_n;
      int unsigned old_rank;
      r         = '0;
      hit_slot  = -1;
      free_slot = -1;
      if (op == OpClear) begin
        empty_directory();
        r.last = 1'b1;
        outcome_q.push_back(r);
        return;
      end
      for (int i = 0; i < DirSlots; i++) begin
        if (hit_slot < 0 && slot_used[i] && slot_obj[i] == obj && slot_gen[i] == gen) begin
          hit_slot = i;
        end
      end
      if (hit_slot >= 0) begin
        old_rank = slot_rank[hit_slot];
        for (int i = 0; i < DirSlots; i++) begin
          if (slot_used[i] && slot_rank[i] < old_rank) slot_rank[i]++;
        end
        slot_rank[hit_slot] = 0;
        r.hit  = 1'b1;
        r.occ  = held[OccBits-1:0];
        r.last = 1'b1;
        outcome_q.push_back(r);
        return;
      end
      // miss: saturate capacity, zero still leaves room for the new key
      eff = (capacity > DirSlots) ? DirSlots : capacity;
      if (eff < 1) eff = 1;
      evict_n = (held + 1 > eff) ? held + 1 - eff : 0;
      for (int e = 0; e < evict_n; e++) begin
        victim = -1;
        for (int i = 0; i < DirSlots; i++) begin
          if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        end
        slot_used[victim] = 1'b0;
        held--;
        r          = '0;
        r.ev_valid = 1'b1;
        r.ev_obj   = slot_obj[victim];
        r.ev_gen   = slot_gen[victim];
        r.occ      = OccBits'(held + 1);
        r.last     = (e == evict_n - 1);
        outcome_q.push_back(r);
      end
      for (int i = 0; i < DirSlots; i++) begin
        if (slot_used[i]) slot_rank[i]++;
        else if (free_slot < 0) free_slot = i;
      end
      slot_obj[free_slot]  = obj;
      slot_gen[free_slot]  = gen;
      slot_used[free_slot] = 1'b1;
      slot_rank[free_slot] = 0;
      held++;
      if (evict_n == 0) begin
        r      = '0;
        r.occ  = held[OccBits-1:0];
        r.last = 1'b1;
        outcome_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_outcome(result_t got);
      result_t exp_r;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0h", $time, got);
        mismatches++;
        return;
      end
      exp_r = outcome_q[0];
      outcome_q.delete(0);
      compare_field("hit", exp_r.hit, got.hit);
      compare_field("evicted_valid", exp_r.ev_valid, got.ev_valid);
      compare_field("evicted_object", exp_r.ev_obj, got.ev_obj);
      compare_field("evicted_generation", exp_r.ev_gen, got.ev_gen);
      compare_field("occupancy", exp_r.occ, got.occ);
      compare_field("last", exp_r.last, got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // object_number, generation, pad
  logic [0:0]  s_axis_tuser = '0;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // evicted_object, evicted_generation, occupancy, pad
  logic [1:0]  m_axis_tuser;        // hit, evicted_valid
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;

  lru_directory_scoreboard sb;
  bit                      idle_on = 1'b1;
  int unsigned             ready_hold = 0;
  int unsigned             ready_roll;
  longint unsigned         cycle_cnt = 0;
  logic [ObjBits-1:0]      pool_obj [PoolSize];
  logic [GenBits-1:0]      pool_gen [PoolSize];

  lru_reference_cache_directory_unit #(
    .SLOTS(DirSlots)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit      = m_axis_tuser[0];
      got.ev_valid = m_axis_tuser[1];
      got.ev_obj   = m_axis_tdata[22:0];
      got.ev_gen   = m_axis_tdata[38:23];
      got.occ      = m_axis_tdata[43:39];
      got.last     = m_axis_tlast;
      sb.check_outcome(got);
    end
  end

  // receiver backpressure while idle_on: short random stalls, an occasional long one
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold    <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 3) begin
        ready_hold    <= $urandom_range(8, 25);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (ready_roll < 70);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(op_e op, logic [ObjBits-1:0] obj, logic [GenBits-1:0] gen);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, gen, obj};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_request(op, obj, gen);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic access_key(logic [ObjBits-1:0] obj, logic [GenBits-1:0] gen);
    send_request(OpAccess, obj, gen);
  endtask

  task automatic drain_outcomes();
    s_axis_tvalid <= 1'b0;
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CapBits-1:0] value);
    drain_outcomes();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.capacity = value;
  endtask

  initial begin
    logic [CapBits-1:0] phase_cap  [NumPhases];
    int unsigned        phase_len  [NumPhases];
    int unsigned        phase_span [NumPhases];
    int unsigned        base;
    int unsigned        idx;
    int unsigned        roll;

    phase_cap  = '{5'd31, 5'd0, 5'd16, 5'd1, 5'd5, 5'd17, 5'd3, 5'd12, 5'd2};
    phase_len  = '{40, 25, 40, 25, 35, 30, 30, 30, 25};
    phase_span = '{24, 4, 20, 3, 8, 24, 6, 16, 5};

    sb = new();
    for (int i = 0; i < PoolSize; i++) begin
      pool_obj[i] = ObjBits'($urandom());
      pool_gen[i] = GenBits'($urandom());
    end
    pool_obj[0] = '0;
    pool_gen[0] = '0;
    pool_obj[1] = '1;
    pool_gen[1] = '1;
    pool_obj[2] = '0;
    pool_gen[2] = '1;
    pool_obj[3] = '1;
    pool_gen[3] = '0;
    // keys that share only the object number or only the generation
    pool_obj[4] = pool_obj[6];
    pool_gen[5] = pool_gen[7];

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // lru replacement with two entries, extreme keys, partial key matches
    write_capacity(5'd2);
    access_key('0, '0);
    access_key('1, '1);
    access_key('0, '0);
    access_key('0, '1);
    access_key('1, '0);
    send_request(OpClear, ObjBits'($urandom()), GenBits'($urandom()));
    access_key('0, '0);

    // zero capacity keeps only the newest key
    write_capacity(5'd0);
    access_key(23'h2a5a5a, 16'h5a5a);
    access_key(23'h55a5a5, 16'ha5a5);
    access_key(23'h55a5a5, 16'ha5a5);

    // lowering capacity: hits keep everything, the next miss evicts down to one
    write_capacity(5'd16);
    send_request(OpClear, '1, '1);
    for (int i = 0; i < 6; i++) access_key(pool_obj[8 + i], pool_gen[8 + i]);
    write_capacity(5'd1);
    access_key(pool_obj[13], pool_gen[13]);
    access_key(23'h000001, 16'h8000);

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_capacity(phase_cap[ph]);
      idle_on = (ph % 3 != 1);
      base    = $urandom_range(0, PoolSize - 1);
      for (int n = 0; n < phase_len[ph]; n++) begin
        roll = $urandom_range(0, 99);
        idx  = (base + $urandom_range(0, phase_span[ph] - 1)) % PoolSize;
        if (n == 0 || roll >= 88) begin
          access_key(ObjBits'($urandom()), GenBits'($urandom()));
        end else if (roll < 3) begin
          send_request(OpClear, ObjBits'($urandom()), GenBits'($urandom()));
        end else if (roll < 8) begin
          access_key(pool_obj[idx], GenBits'($urandom()));
        end else begin
          access_key(pool_obj[idx], pool_gen[idx]);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outcome_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
